// ===== design/srs_pkg.sv =====
// shared types, codes and helpers for the string instruction sequencer
package srs_pkg;

    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_ELEM  = 1'b1;

    localparam logic [2:0] KIND_MOVS = 3'd0;
    localparam logic [2:0] KIND_STOS = 3'd1;
    localparam logic [2:0] KIND_LODS = 3'd2;
    localparam logic [2:0] KIND_CMPS = 3'd3;
    localparam logic [2:0] KIND_SCAS = 3'd4;
    localparam logic [2:0] KIND_INS  = 3'd5;
    localparam logic [2:0] KIND_OUTS = 3'd6;

    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_WORD  = 2'd1;
    localparam logic [1:0] SIZE_DWORD = 2'd2;

    localparam logic [1:0] REP_NONE  = 2'd0;
    localparam logic [1:0] REP_REPE  = 2'd1;
    localparam logic [1:0] REP_REPNE = 2'd2;

    localparam int FLAG_CF = 0;
    localparam int FLAG_PF = 1;
    localparam int FLAG_AF = 2;
    localparam int FLAG_ZF = 3;
    localparam int FLAG_SF = 4;
    localparam int FLAG_OF = 5;

    localparam logic [31:0] OFS_MASK16 = 32'h0000_FFFF;
    localparam logic [31:0] OFS_MASK32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        op;
        logic [2:0]  kind;
        logic [1:0]  size;
        logic [1:0]  rep;
        logic        addr32;
        logic        df;
        logic [15:0] count;
        logic [31:0] src_ofs;
        logic [31:0] dst_ofs;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } cmd_t;

    typedef struct packed {
        logic [31:0] next_src_ofs;
        logic [31:0] next_dst_ofs;
        logic [15:0] count_left;
        logic [31:0] store_value;
        logic [5:0]  flag_bits;
        logic        flags_valid;
        logic        done_res;
    } res_t;

    typedef struct packed {
        logic        active;
        logic [2:0]  kind;
        logic [1:0]  size;
        logic [1:0]  rep;
        logic        addr32;
        logic        df;
        logic [15:0] count;
        logic [31:0] src;
        logic [31:0] dst;
        logic [5:0]  flags;
    } seq_state_t;

    function automatic logic [31:0] elem_mask(input logic [1:0] size);
        logic [31:0] m;
        case (size)
            SIZE_BYTE: m = 32'h0000_00FF;
            SIZE_WORD: m = 32'h0000_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] elem_step(input logic [1:0] size);
        logic [31:0] s;
        case (size)
            SIZE_BYTE: s = 32'd1;
            SIZE_WORD: s = 32'd2;
            default:   s = 32'd4;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] ofs_mask(input logic addr32);
        return addr32 ? OFS_MASK32 : OFS_MASK16;
    endfunction

endpackage

// ===== design/srs_cmp.sv =====
// compare unit: x86 subtract flags at byte, word or doubleword width
module srs_cmp (
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [1:0]  size,
    output logic [5:0]  flags
);

    logic [31:0] mask;
    logic [31:0] am;
    logic [31:0] bm;
    logic [32:0] diff;
    logic [31:0] r;
    logic        top_r;
    logic        top_ovf;
    logic [31:0] ovf_vec;

    always_comb
    begin
        mask    = srs_pkg::elem_mask(size);
        am      = a & mask;
        bm      = b & mask;
        diff    = {1'b0, am} - {1'b0, bm};
        r       = diff[31:0] & mask;
        ovf_vec = (am ^ bm) & (am ^ r);
        case (size)
            srs_pkg::SIZE_BYTE:
            begin
                top_r   = r[7];
                top_ovf = ovf_vec[7];
            end
            srs_pkg::SIZE_WORD:
            begin
                top_r   = r[15];
                top_ovf = ovf_vec[15];
            end
            default:
            begin
                top_r   = r[31];
                top_ovf = ovf_vec[31];
            end
        endcase
        flags                  = '0;
        // masked operands, so bit 32 of the difference is the borrow
        flags[srs_pkg::FLAG_CF] = diff[32];
        flags[srs_pkg::FLAG_PF] = ~^r[7:0];
        flags[srs_pkg::FLAG_AF] = am[4] ^ bm[4] ^ r[4];
        flags[srs_pkg::FLAG_ZF] = (r == 32'd0);
        flags[srs_pkg::FLAG_SF] = top_r;
        flags[srs_pkg::FLAG_OF] = top_ovf;
    end

endmodule

// ===== design/srs_step.sv =====
// next-state and result logic for one request
module srs_step (
    input  srs_pkg::seq_state_t st,
    input  srs_pkg::cmd_t       cmd,
    output srs_pkg::seq_state_t st_next,
    output srs_pkg::res_t       res,
    output logic                emit
);

    logic [5:0]  cmp_flags;
    logic        use_si;
    logic        use_di;
    logic        is_cmp;
    logic [31:0] step;
    logic [31:0] omask;
    logic [31:0] store;
    logic [15:0] cnt_dec;
    logic        done;
    logic        zf;
    logic        start_done;

    srs_cmp u_cmp (
        .a     (cmd.operand_a),
        .b     (cmd.operand_b),
        .size  (st.size),
        .flags (cmp_flags)
    );

    always_comb
    begin
        use_si = 1'b0;
        use_di = 1'b0;
        is_cmp = 1'b0;
        case (st.kind)
            srs_pkg::KIND_STOS: use_di = 1'b1;
            srs_pkg::KIND_LODS: use_si = 1'b1;
            srs_pkg::KIND_CMPS:
            begin
                use_si = 1'b1;
                use_di = 1'b1;
                is_cmp = 1'b1;
            end
            srs_pkg::KIND_SCAS:
            begin
                use_di = 1'b1;
                is_cmp = 1'b1;
            end
            srs_pkg::KIND_INS:  use_di = 1'b1;
            srs_pkg::KIND_OUTS: use_si = 1'b1;
            default:
            begin
                // movs, and the unused kind code behaves the same
                use_si = 1'b1;
                use_di = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        st_next    = st;
        emit       = 1'b0;
        done       = 1'b0;
        store      = '0;
        step       = srs_pkg::elem_step(st.size);
        omask      = srs_pkg::ofs_mask(st.addr32);
        cnt_dec    = st.count - 16'd1;
        zf         = cmp_flags[srs_pkg::FLAG_ZF];
        start_done = (cmd.rep != srs_pkg::REP_NONE) && (cmd.count == 16'd0);

        if (cmd.op == srs_pkg::OP_BEGIN)
        begin
            emit           = 1'b1;
            st_next.kind   = cmd.kind;
            st_next.size   = cmd.size;
            st_next.rep    = cmd.rep;
            st_next.addr32 = cmd.addr32;
            st_next.df     = cmd.df;
            st_next.count  = cmd.count;
            st_next.src    = cmd.src_ofs & srs_pkg::ofs_mask(cmd.addr32);
            st_next.dst    = cmd.dst_ofs & srs_pkg::ofs_mask(cmd.addr32);
            st_next.active = ~start_done;
            done           = start_done;
        end
        else if (st.active)
        begin
            emit = 1'b1;
            if (st.rep != srs_pkg::REP_NONE)
                st_next.count = cnt_dec;
            if (is_cmp)
                st_next.flags = cmp_flags;
            else
                store = cmd.operand_a & srs_pkg::elem_mask(st.size);
            if (use_si)
                st_next.src = (st.df ? st.src - step : st.src + step) & omask;
            if (use_di)
                st_next.dst = (st.df ? st.dst - step : st.dst + step) & omask;

            if (st.rep == srs_pkg::REP_NONE)
                done = 1'b1;
            else
            begin
                if (cnt_dec == 16'd0)
                    done = 1'b1;
                // repne stops on equal, repe (and the unused prefix code) on unequal
                if (is_cmp && (st.rep == srs_pkg::REP_REPNE) && zf)
                    done = 1'b1;
                if (is_cmp && (st.rep != srs_pkg::REP_REPNE) && !zf)
                    done = 1'b1;
            end
            if (done)
                st_next.active = 1'b0;
        end

        res.next_src_ofs = st_next.src;
        res.next_dst_ofs = st_next.dst;
        res.count_left   = st_next.count;
        res.store_value  = store;
        res.flag_bits    = st_next.flags;
        res.flags_valid  = (cmd.op == srs_pkg::OP_ELEM) && is_cmp;
        res.done_res     = done;
    end

endmodule

// ===== design/x86_string_instruction_sequencer.sv =====
// top level: x86 string instruction sequencer
// latency: a result is valid in the cycle after its request is accepted
// throughput: one request per cycle; cmd_ready stays high while the result
//   register is empty or being drained in the same cycle
// element requests that arrive with no instruction running are taken and dropped
// reset: rst_n clears the instruction state and the result valid flag
module x86_string_instruction_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  srs_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output srs_pkg::res_t res
);

    srs_pkg::seq_state_t st_reg;
    srs_pkg::seq_state_t st_next;
    srs_pkg::res_t       res_reg;
    srs_pkg::res_t       res_next;
    logic                res_valid_reg;
    logic                emit;
    logic                accept;

    assign cmd_ready = ~res_valid_reg | res_ready;
    assign accept    = cmd_valid & cmd_ready;

    srs_step u_step (
        .st      (st_reg),
        .cmd     (cmd),
        .st_next (st_next),
        .res     (res_next),
        .emit    (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                st_reg        <= st_next;
                res_valid_reg <= emit;
            end
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== design/srs_checker.sv =====
// port-level checks for the string instruction sequencer, bound to the top level
module srs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input srs_pkg::cmd_t cmd,
    input logic          res_valid,
    input logic          res_ready,
    input srs_pkg::res_t res
);

    // a waiting result holds still
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // a full result register that is not drained blocks new requests
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !cmd_ready)
        else $error("request taken over a stalled result");

    // a begin request always answers, with no store value and no flags
    a_begin_res: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.op == srs_pkg::OP_BEGIN)
        |=> res_valid && !res.flags_valid && (res.store_value == 32'd0))
        else $error("bad begin result");

    // repeated instruction with zero count finishes at once with the loaded count
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.op == srs_pkg::OP_BEGIN)
        && (cmd.rep != srs_pkg::REP_NONE) && (cmd.count == 16'd0)
        |=> res_valid && res.done_res && (res.count_left == 16'd0))
        else $error("zero count did not finish");

endmodule

bind x86_string_instruction_sequencer srs_checker u_srs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
